### rtl/rha_pkg.sv
// rha_pkg: shared types, codes and controller state enum for the handle allocator
// used by rha_ctrl, rha_dpath and the top level
package rha_pkg;

    typedef struct packed {
        logic [2:0]  action;
        logic [16:0] object_size;
        logic [15:0] handle_in;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] handle_out;
        logic [15:0] start_address;
        logic [15:0] ref_count;
        logic        compacted;
        logic [16:0] bytes_collected;
    } t_rsp;

    localparam logic [2:0] ACT_INSERT   = 3'd0;
    localparam logic [2:0] ACT_RETRIEVE = 3'd1;
    localparam logic [2:0] ACT_ADD      = 3'd2;
    localparam logic [2:0] ACT_DROP     = 3'd3;
    localparam logic [2:0] ACT_CLEAR    = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_NOMEM     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND  = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_EXHAUSTED = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_SEARCH_WAIT,
        S_HIT,
        S_SHIFT,
        S_COMPACT,
        S_COMPACT_WAIT,
        S_INSERT,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic clear_all;
        logic idx_zero;
        logic idx_inc;
        logic rd_issue;      // read entry at idx (idx+2 during a shift step)
        logic compact_init;
        logic compact_step;
        logic compact_done;
        logic do_insert;
        logic do_hit;        // retrieve/add/drop on slot idx
        logic shift_step;
        logic shift_done;
        logic set_status;
        logic [2:0] status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [2:0] action;
        logic size_zero;
        logic handle_zero;
        logic exhausted;
        logic full;
        logic fits;
        logic idx_last;      // idx at live count - 1 or beyond
        logic idx_end;       // idx >= live count
        logic hit;           // entry at idx matches handle
        logic need_remove;
        logic add_sat;
    } t_sts;

endpackage

### rtl/rha_ctrl.sv
// rha_ctrl: sequencer for search, compaction, insert and removal walks
// depends on rha_pkg
module rha_ctrl
    import rha_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.idx_zero = 1'b1;
                n_state = S_OUT;
                o_cmd.set_status = 1'b1;
                o_cmd.status = ST_OK;
                case (i_sts.action)
                    ACT_INSERT: begin
                        if (i_sts.size_zero) begin
                            o_cmd.status = ST_INVALID;
                        end else if (i_sts.exhausted) begin
                            o_cmd.status = ST_EXHAUSTED;
                        end else if (i_sts.full) begin
                            o_cmd.status = ST_FULL;
                        end else if (i_sts.fits) begin
                            n_state = S_INSERT;
                        end else begin
                            o_cmd.compact_init = 1'b1;
                            n_state = S_COMPACT;
                        end
                    end
                    ACT_RETRIEVE, ACT_ADD, ACT_DROP: begin
                        if (i_sts.handle_zero) begin
                            o_cmd.status = ST_INVALID;
                        end else begin
                            o_cmd.status = ST_NOTFOUND;
                            n_state = S_SEARCH;
                        end
                    end
                    ACT_CLEAR: begin
                        o_cmd.clear_all = 1'b1;
                    end
                    default: begin
                        o_cmd.status = ST_INVALID;
                    end
                endcase
            end
            S_SEARCH: begin
                if (i_sts.idx_end) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    n_state = S_SEARCH_WAIT;
                end
            end
            S_SEARCH_WAIT: begin
                if (i_sts.hit) begin
                    n_state = S_HIT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_SEARCH;
                end
            end
            S_HIT: begin
                o_cmd.do_hit = 1'b1;
                o_cmd.set_status = 1'b1;
                o_cmd.status = (i_sts.action == ACT_ADD && i_sts.add_sat) ? ST_INVALID
                                                                            : ST_OK;
                if (i_sts.action == ACT_DROP && i_sts.need_remove) begin
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_SHIFT: begin
                // entry idx+1 was read last cycle; move it down or finish
                if (i_sts.idx_last) begin
                    o_cmd.shift_done = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.shift_step = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                    o_cmd.rd_issue = 1'b1;
                end
            end
            S_COMPACT: begin
                if (i_sts.idx_end) begin
                    o_cmd.compact_done = 1'b1;
                    n_state = S_INSERT;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    n_state = S_COMPACT_WAIT;
                end
            end
            S_COMPACT_WAIT: begin
                o_cmd.compact_step = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state = S_COMPACT;
            end
            S_INSERT: begin
                o_cmd.set_status = 1'b1;
                if (i_sts.fits) begin
                    o_cmd.do_insert = 1'b1;
                    o_cmd.status = ST_OK;
                end else begin
                    o_cmd.status = ST_NOMEM;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_stall && i_valid) |=> r_state == S_DECODE)
        else $error("accepted request not decoded");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && !o_stall))
        else $error("accepting while result pending");

endmodule

### rtl/rha_dpath.sv
// rha_dpath: entry tables, request and result registers, walk index and offsets
// depends on rha_pkg
module rha_dpath
    import rha_pkg::*;
#(
    parameter int POOL_BYTES  = 65536,
    parameter int MAX_OBJECTS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output t_rsp o_rsp
);

    localparam int IW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CW = $clog2(MAX_OBJECTS + 1);
    localparam logic [17:0] POOL = 18'(POOL_BYTES);
    localparam logic [CW-1:0] NMAX = CW'(MAX_OBJECTS);

    // entry memory: handle, start, size, count
    logic [15:0] m_handle [MAX_OBJECTS];
    logic [15:0] m_start  [MAX_OBJECTS];
    logic [16:0] m_size   [MAX_OBJECTS];
    logic [15:0] m_count  [MAX_OBJECTS];

    t_req         r_req;
    t_rsp         r_rsp;
    logic [CW-1:0] r_live;
    logic [CW-1:0] r_idx;
    logic [15:0]  r_next_handle;
    logic [16:0]  r_free;
    logic [16:0]  r_pos;
    logic [15:0]  r_rd_handle, r_rd_count;
    logic [15:0]  r_rd_start;
    logic [16:0]  r_rd_size;

    logic [IW-1:0] idx, idx_rd;
    logic [CW-1:0] idx_p1;
    logic [CW-1:0] idx_p2;
    logic [17:0]   fit_sum;

    assign idx    = r_idx[IW-1:0];
    assign idx_p1 = r_idx + CW'(1);
    assign idx_p2 = r_idx + CW'(2);
    // shift walk reads ahead of the slot being written
    assign idx_rd = i_cmd.shift_step ? idx_p2[IW-1:0]
                  : (i_cmd.do_hit && r_req.action == ACT_DROP) ? idx_p1[IW-1:0] : idx;
    assign fit_sum = {1'b0, r_free} + {1'b0, r_req.object_size};

    always_comb begin
        o_sts.action      = r_req.action;
        o_sts.size_zero   = (r_req.object_size == '0);
        o_sts.handle_zero = (r_req.handle_in == '0);
        o_sts.exhausted   = (r_next_handle == '0);
        o_sts.full        = (r_live >= NMAX);
        o_sts.fits        = (fit_sum <= POOL);
        o_sts.idx_last    = (idx_p1 >= r_live);
        o_sts.idx_end     = (r_idx >= r_live);
        o_sts.hit         = (r_rd_handle == r_req.handle_in);
        o_sts.need_remove = (r_rd_count <= 16'd1);
        o_sts.add_sat     = (r_rd_count == 16'hFFFF);
    end

    // memory ports: one read, one write per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue || (i_cmd.do_hit && r_req.action == ACT_DROP)) begin
            r_rd_handle <= m_handle[idx_rd];
            r_rd_start  <= m_start[idx_rd];
            r_rd_size   <= m_size[idx_rd];
            r_rd_count  <= m_count[idx_rd];
        end
        if (i_cmd.do_insert) begin
            m_handle[r_live[IW-1:0]] <= r_next_handle;
            m_start[r_live[IW-1:0]]  <= r_free[15:0];
            m_size[r_live[IW-1:0]]   <= r_req.object_size;
            m_count[r_live[IW-1:0]]  <= 16'd1;
        end else if (i_cmd.compact_step) begin
            m_start[idx] <= r_pos[15:0];
        end else if (i_cmd.shift_step) begin
            m_handle[idx] <= r_rd_handle;
            m_start[idx]  <= r_rd_start;
            m_size[idx]   <= r_rd_size;
            m_count[idx]  <= r_rd_count;
        end else if (i_cmd.do_hit && r_req.action != ACT_RETRIEVE) begin
            if (r_req.action == ACT_ADD && r_rd_count != 16'hFFFF) begin
                m_count[idx] <= r_rd_count + 16'd1;
            end else if (r_req.action == ACT_DROP && r_rd_count > 16'd1) begin
                m_count[idx] <= r_rd_count - 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
        end
        if (i_cmd.idx_zero || i_cmd.compact_init) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= idx_p1;
        end
        if (i_cmd.compact_init) begin
            r_pos <= '0;
        end else if (i_cmd.compact_step) begin
            r_pos <= r_pos + r_rd_size;
        end

        if (i_cmd.load_req) begin
            r_rsp <= '0;
        end else begin
            if (i_cmd.set_status) begin
                r_rsp.status <= i_cmd.status;
            end
            if (i_cmd.compact_done) begin
                r_rsp.compacted <= 1'b1;
                r_rsp.bytes_collected <= (r_free >= r_pos) ? r_free - r_pos : '0;
            end
            if (i_cmd.do_insert) begin
                r_rsp.handle_out    <= r_next_handle;
                r_rsp.start_address <= r_free[15:0];
                r_rsp.ref_count     <= 16'd1;
            end
            if (i_cmd.do_hit) begin
                case (r_req.action)
                    ACT_RETRIEVE: begin
                        r_rsp.start_address <= r_rd_start;
                        r_rsp.ref_count     <= r_rd_count;
                    end
                    ACT_ADD: begin
                        r_rsp.ref_count <= (r_rd_count == 16'hFFFF) ? 16'hFFFF
                                                                    : r_rd_count + 16'd1;
                    end
                    default: begin
                        r_rsp.ref_count <= (r_rd_count <= 16'd1) ? 16'd0
                                                                 : r_rd_count - 16'd1;
                    end
                endcase
            end
        end

        if (!i_rst_n) begin
            r_live        <= '0;
            r_next_handle <= 16'd1;
            r_free        <= '0;
        end else begin
            if (i_cmd.clear_all) begin
                r_live        <= '0;
                r_next_handle <= 16'd1;
                r_free        <= '0;
            end else if (i_cmd.compact_done) begin
                r_free <= r_pos;
            end else if (i_cmd.do_insert) begin
                r_live        <= r_live + CW'(1);
                r_next_handle <= r_next_handle + 16'd1;
                r_free        <= fit_sum[16:0];
            end else if (i_cmd.shift_done) begin
                r_live <= r_live - CW'(1);
            end
        end
    end

    assign o_rsp = r_rsp;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_live <= NMAX)
        else $error("live count beyond table");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_insert |-> (r_live < NMAX && fit_sum <= POOL))
        else $error("insert without room");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift_done |-> r_live != '0)
        else $error("removal from empty table");

endmodule

### rtl/refcount_handle_allocator_compacting.sv
// Object table of a compacting bump allocator with reference counts.
//
// Request channel i_valid/o_stall carries t_req (action, size, handle);
// result channel o_valid/i_stall carries one t_rsp per request.
// A transfer happens when valid is high and stall is low.
// One request is handled at a time: the block raises o_stall from the
// cycle after a transfer until its result has been taken, and takes the
// next request in the cycle after the result transfer.
// Sequence: an insert that fits goes from decode to the insert state and
// then to the result; status-only commands go from decode straight to the
// result; retrieve/add/drop walk the table one entry at a time up to the
// match, issuing a read and then checking it; a drop that frees removes the
// entry by moving each later entry down one slot; an insert that compacts
// walks all live entries first. The entry memory gives one read per cycle.
// Reset (synchronous, i_rst_n low) empties the table, sets the next
// handle to 1 and the free offset to 0; no clearing pass is needed.
// While i_stall is high the result holds and no new request is taken.
// depends on rha_pkg, rha_ctrl, rha_dpath
module refcount_handle_allocator_compacting
    import rha_pkg::*;
#(
    parameter int POOL_BYTES  = 65536,
    parameter int MAX_OBJECTS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_data
);

    t_cmd cmd;
    t_sts sts;

    rha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    rha_dpath #(
        .POOL_BYTES  (POOL_BYTES),
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_data),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_data)
    );

endmodule
